// ===== sv/wss_pkg.sv =====
// Shared constants and types for the windowed sample statistics block.
// No dependencies; imported by every module of the block.
`default_nettype none

package wss_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COUNT_W    = 8;
    localparam int LEN_W      = 8;
    localparam int SPAN_W     = 4;
    localparam int SUM_W      = 28;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_ABOVE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_SPAN       = 2'd3;

    localparam logic [SAMPLE_W-1:0] RST_GATE_THRESHOLD = 24'd768;
    localparam logic                RST_ACCEPT_ABOVE   = 1'b1;
    localparam logic [LEN_W-1:0]    RST_WINDOW_LEN     = 8'd128;
    localparam logic [SPAN_W-1:0]   RST_AVG_SPAN       = 4'd10;

    typedef struct packed {
        logic              start;
        logic [SPAN_W-1:0] divisor;
    } div_req_t;

endpackage

`default_nettype wire

// ===== sv/windowed_sample_statistics.sv =====
// Windowed sample statistics: outlier gate, sliding window of the newest
// samples, min/max/mean per request. Depends on wss_pkg, wss_cell, wss_divider.
//
// Samples live in a chain of WINDOW_DEPTH cells, newest at the head. A request
// is accepted (and a kept sample stored) in ST_IDLE; ST_SCAN then rotates the
// chain once past its tail (min, max and sum gathered there), ST_DIV runs the
// bit-serial divider and ST_OUT loads the output register. A new request is
// taken while the previous result still waits in the output register.
`default_nettype none

module windowed_sample_statistics
    import wss_pkg::*;
#(
    parameter int WINDOW_DEPTH = 128
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [SAMPLE_W-1:0]   s_sample,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_kept,
    output logic      [COUNT_W-1:0]    m_count,
    output logic      [SAMPLE_W-1:0]   m_window_min,
    output logic      [SAMPLE_W-1:0]   m_window_max,
    output logic      [SAMPLE_W-1:0]   m_mean,
    output logic                       m_mean_valid
);

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int POS_W = $clog2(WINDOW_DEPTH);
    localparam int CW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DIV, ST_OUT} state_t;

    state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] thr_reg;
    logic                above_reg;
    logic [LEN_W-1:0]    wlen_reg;
    logic [SPAN_W-1:0]   span_reg;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                kept_reg, kept_next;
    logic [SAMPLE_W-1:0] min_reg, min_next;
    logic [SAMPLE_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                div_start_reg, div_start_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_kept_reg;
    logic [COUNT_W-1:0]  m_count_reg;
    logic [SAMPLE_W-1:0] m_min_reg, m_max_reg, m_mean_reg;
    logic                m_mean_valid_reg;

    logic [SAMPLE_W-1:0] cell_q [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] chain_head, tail;
    logic                chain_shift;

    logic                s_fire, keep, out_load, mean_ok;
    logic [CW-1:0]       wl_w, eff_len, cnt_w, cnt_inc, cnt_upd;
    logic [CW-1:0]       span_w, cm1, n_w, pos_w;
    logic                in_win, in_mean;
    div_req_t            div_req;
    logic [SUM_W-1:0]    quotient;
    logic                div_done;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= RST_GATE_THRESHOLD;
            above_reg <= RST_ACCEPT_ABOVE;
            wlen_reg  <= RST_WINDOW_LEN;
            span_reg  <= RST_AVG_SPAN;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GATE_THRESHOLD: thr_reg   <= cfg_wdata[SAMPLE_W-1:0];
                REG_ACCEPT_ABOVE:   above_reg <= cfg_wdata[0];
                REG_WINDOW_LEN:     wlen_reg  <= cfg_wdata[LEN_W-1:0];
                REG_AVG_SPAN:       span_reg  <= cfg_wdata[SPAN_W-1:0];
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign keep    = above_reg ? (s_sample > thr_reg) : (s_sample <= thr_reg);

    // cell chain
    assign tail        = cell_q[WINDOW_DEPTH-1];
    assign chain_shift = (s_fire && keep) || (state_reg == ST_SCAN);
    assign chain_head  = (state_reg == ST_SCAN) ? tail : s_sample;

    for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            wss_cell u_cell (
                .aclk     (aclk),
                .shift_en (chain_shift),
                .d_in     (chain_head),
                .q_out    (cell_q[i])
            );
        end else begin : g_body
            wss_cell u_cell (
                .aclk     (aclk),
                .shift_en (chain_shift),
                .d_in     (cell_q[i-1]),
                .q_out    (cell_q[i])
            );
        end
    end

    // count update: store, then trim to the effective length
    assign wl_w    = CW'(wlen_reg);
    assign eff_len = (wl_w == '0) ? CW'(1) :
                     (wl_w > CW'(WINDOW_DEPTH)) ? CW'(WINDOW_DEPTH) : wl_w;
    assign cnt_w   = CW'(count_reg);
    assign cnt_inc = (keep && (cnt_w < CW'(WINDOW_DEPTH))) ? cnt_w + CW'(1) : cnt_w;
    assign cnt_upd = (cnt_inc > eff_len) ? eff_len : cnt_inc;

    // mean span: min(avg_span, count - 1), with avg_span 0 taken as 1
    assign span_w  = (span_reg == '0) ? CW'(1) : CW'(span_reg);
    assign cm1     = cnt_w - CW'(1);
    assign n_w     = (cm1 < span_w) ? cm1 : span_w;
    assign mean_ok = cnt_w >= CW'(2);

    // tail position, newest = 0
    assign pos_w   = CW'(pos_reg);
    assign in_win  = pos_w < cnt_w;
    assign in_mean = mean_ok && (pos_w < n_w);

    assign div_req.start   = div_start_reg;
    assign div_req.divisor = n_w[SPAN_W-1:0];

    wss_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (sum_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        kept_next      = kept_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        div_start_next = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    kept_next  = keep;
                    count_next = CNT_W'(cnt_upd);
                    pos_next   = POS_W'(WINDOW_DEPTH - 1);
                    min_next   = '1;
                    max_next   = '0;
                    sum_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (in_win) begin
                    if (tail < min_reg) min_next = tail;
                    if (tail > max_reg) max_next = tail;
                end
                if (in_mean) begin
                    sum_next = sum_reg + SUM_W'(tail);
                end
                pos_next = pos_reg - 1'b1;
                if (pos_reg == '0) begin
                    div_start_next = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
        m_valid_next = out_load ? 1'b1 : ((m_valid_reg && m_ready) ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            div_start_reg <= div_start_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        kept_reg <= kept_next;
        min_reg  <= min_next;
        max_reg  <= max_next;
        sum_reg  <= sum_next;
        if (out_load) begin
            m_kept_reg       <= kept_reg;
            m_count_reg      <= cnt_w[COUNT_W-1:0];
            m_min_reg        <= (count_reg == '0) ? '0 : min_reg;
            m_max_reg        <= (count_reg == '0) ? '0 : max_reg;
            m_mean_reg       <= mean_ok ? quotient[SAMPLE_W-1:0] : '0;
            m_mean_valid_reg <= mean_ok;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kept       = m_kept_reg;
    assign m_count      = m_count_reg;
    assign m_window_min = m_min_reg;
    assign m_window_max = m_max_reg;
    assign m_mean       = m_mean_reg;
    assign m_mean_valid = m_mean_valid_reg;

endmodule

`default_nettype wire

// ===== sv/wss_cell.sv =====
// One window cell: holds a single sample and passes it on to its neighbor.
// Depends on wss_pkg.
`default_nettype none

module wss_cell
    import wss_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                shift_en,
    input  wire logic [SAMPLE_W-1:0] d_in,
    output logic      [SAMPLE_W-1:0] q_out
);

    logic [SAMPLE_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= d_in;
        end
    end

    assign q_out = data_reg;

endmodule

`default_nettype wire

// ===== sv/wss_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the windowed mean.
// Depends on wss_pkg.
`default_nettype none

module wss_divider
    import wss_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire div_req_t         req,
    input  wire logic [SUM_W-1:0] dividend,
    output logic      [SUM_W-1:0] quotient,
    output logic                  done
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [SPAN_W-1:0]    rem_reg, rem_next;
    logic [SPAN_W-1:0]    div_reg, div_next;
    logic [SPAN_W:0]      trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[SUM_W-2:0], ge};
            rem_next  = ge ? SPAN_W'(trial - {1'b0, div_reg}) : SPAN_W'(trial);
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== sv/wss_checker.sv =====
// Port-level checks for windowed_sample_statistics, bound to the top level.
// Depends on wss_pkg.
`default_nettype none

module wss_checker
    import wss_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [COUNT_W-1:0]  m_count,
    input wire logic [SAMPLE_W-1:0] m_window_min,
    input wire logic [SAMPLE_W-1:0] m_window_max,
    input wire logic [SAMPLE_W-1:0] m_mean,
    input wire logic                m_mean_valid
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mean) && $stable(m_count))
        else $error("result changed while stalled");

    a_mean_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_mean_valid == (m_count >= COUNT_W'(2))))
        else $error("mean_valid does not match count");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_count == '0) |-> (m_window_min == '0) && (m_window_max == '0))
        else $error("empty window reports nonzero min/max");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mean_valid |->
            (m_window_min <= m_mean) && (m_mean <= m_window_max))
        else $error("mean outside min/max");

endmodule

bind windowed_sample_statistics wss_checker u_wss_checker (.*);

`default_nettype wire
